### sv/lh_pkg.sv
// ----------------------------------------------------------------------------
// Luma histogram package
// Shared widths, luma weights, function codes and the bin store write request.
// ----------------------------------------------------------------------------
`default_nettype none

package lh_pkg;

  localparam int CountWidth = 24;
  localparam int OutWidth   = 24;
  localparam int ColorWidth = 8;
  localparam int BinWidth   = 8;
  localparam int BinDepth   = 1 << BinWidth;
  localparam int LumaFrac   = 16;
  localparam int SumWidth   = LumaFrac + ColorWidth;

  localparam logic [LumaFrac-1:0] LumaKr = 16'd19595;
  localparam logic [LumaFrac-1:0] LumaKg = 16'd38470;
  localparam logic [LumaFrac-1:0] LumaKb = 16'd7471;

  localparam logic FuncAccum = 1'b0;
  localparam logic FuncRead  = 1'b1;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [OutWidth-1:0]   out_count_t;
  typedef logic [ColorWidth-1:0] color_t;
  typedef logic [BinWidth-1:0]   bin_t;

  localparam count_t CountMax = '1;

  typedef struct packed {
    logic   en;
    bin_t   addr;
    count_t data;
  } wr_req_t;

endpackage

`default_nettype wire

### sv/lh_if.sv
// ----------------------------------------------------------------------------
// Luma histogram channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface lh_in_if;
  import lh_pkg::*;

  logic   valid;
  logic   ready;
  logic   func;
  color_t red;
  color_t green;
  color_t blue;
  bin_t   bin_index;

  modport source (output valid, func, red, green, blue, bin_index, input ready);
  modport sink   (input valid, func, red, green, blue, bin_index, output ready);
endinterface

interface lh_out_if;
  import lh_pkg::*;

  logic       valid;
  logic       ready;
  out_count_t bin_count;
  out_count_t peak_count;

  modport source (output valid, bin_count, peak_count, input ready);
  modport sink   (input valid, bin_count, peak_count, output ready);
endinterface

`default_nettype wire

### sv/lh_luma.sv
// ----------------------------------------------------------------------------
// Luma converter
// BT.601 weighted sum with 16 fractional bits, truncated to 8-bit luma.
// ----------------------------------------------------------------------------
`default_nettype none

module lh_luma (
  input  lh_pkg::color_t red_i,
  input  lh_pkg::color_t green_i,
  input  lh_pkg::color_t blue_i,
  output lh_pkg::bin_t   luma_o
);
  import lh_pkg::*;

  logic [SumWidth-1:0] sum;

  assign sum = SumWidth'(LumaKr) * SumWidth'(red_i)
             + SumWidth'(LumaKg) * SumWidth'(green_i)
             + SumWidth'(LumaKb) * SumWidth'(blue_i);

  assign luma_o = sum[SumWidth-1 -: BinWidth];

endmodule

`default_nettype wire

### sv/lh_bin_store.sv
// ----------------------------------------------------------------------------
// Bin store
// 256-entry count memory with registered read and per-entry valid bits;
// an entry never written reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lh_bin_store (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  lh_pkg::bin_t    rd_addr_i,
  output lh_pkg::count_t  rd_data_o,
  input  lh_pkg::wr_req_t wr_i
);
  import lh_pkg::*;

  count_t               mem [BinDepth];
  logic [BinDepth-1:0]  valid_q;
  logic                 rd_vld_q;
  count_t               rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

### sv/luma_histogram.sv
// A read word's count is registered in the bin store, then in the result register.
// A new word is taken only in the idle state: the bin store's registered read is
//   followed by the write-back, or for a read word by the result load.
// A waiting result stalls only a read word's step, until the sink takes it.
// Reset: asynchronous; clears the valid bits of all bins at once and the peak;
//   no clearing pass.
// ----------------------------------------------------------------------------
// Luma histogram
// RGB to BT.601 luma, saturating bin counts, running peak and bin readout.
// ----------------------------------------------------------------------------
`default_nettype none

module luma_histogram (
  input  logic     clk_i,
  input  logic     rst_ni,
  lh_in_if.sink    in_i,
  lh_out_if.source out_o
);
  import lh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_MOD  = 2'b10
  } state_e;

  state_e     state_q, state_d;
  logic       in_acc;
  logic       out_busy;
  logic       out_load;
  logic       out_valid_q, out_valid_d;
  count_t     peak_q, peak_d;
  out_count_t bin_out_q, peak_out_q;
  logic       func_q;
  bin_t       addr_q;
  bin_t       luma;
  bin_t       rd_addr;
  count_t     rd_cnt;
  count_t     inc;
  wr_req_t    wr;

  lh_luma u_luma (
    .red_i   (in_i.red),
    .green_i (in_i.green),
    .blue_i  (in_i.blue),
    .luma_o  (luma)
  );

  assign rd_addr = (in_i.func == FuncRead) ? in_i.bin_index : luma;

  lh_bin_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_cnt),
    .wr_i      (wr)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_busy   = out_valid_q & ~out_o.ready;
  assign inc        = (rd_cnt == CountMax) ? rd_cnt : rd_cnt + count_t'(1);

  always_comb begin
    state_d     = state_q;
    peak_d      = peak_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_load    = 1'b0;
    wr          = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (func_q == FuncRead) begin
          if (!out_busy) begin
            out_load    = 1'b1;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          wr.en   = 1'b1;
          wr.addr = addr_q;
          wr.data = inc;
          if (inc > peak_q) begin
            peak_d = inc;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      peak_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      peak_q      <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= in_i.func;
      addr_q <= rd_addr;
    end
    if (out_load) begin
      bin_out_q  <= OutWidth'(rd_cnt);
      peak_out_q <= OutWidth'(peak_q);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.bin_count  = bin_out_q;
  assign out_o.peak_count = peak_out_q;

endmodule

`default_nettype wire

### sv/lh_checker.sv
// ----------------------------------------------------------------------------
// Luma histogram checker
// Port-level assertions on the histogram, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lh_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_func_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input lh_pkg::out_count_t bin_count_i,
  input lh_pkg::out_count_t peak_count_i
);
  import lh_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(bin_count_i) && $stable(peak_count_i))
    else $error("result word changed while stalled");

  a_bin_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> bin_count_i <= peak_count_i)
    else $error("bin count above peak");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken during read-modify-write");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && (in_func_i == FuncRead), 2))
    else $error("result without a read word");

endmodule

bind luma_histogram lh_checker u_lh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_func_i    (in_i.func),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .bin_count_i  (out_o.bin_count),
  .peak_count_i (out_o.peak_count)
);

`default_nettype wire
